### hw/rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps

package lkv_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int RANK_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int KEY_W       = 32;
   localparam int VALUE_W     = 32;
   localparam int CAP_W       = 5;
   localparam int CAP_RESET   = 16;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_WRITE  = 1'b1;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      logic               fire;
      logic               op;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic               hit;
      logic               evict;
      logic [RANK_W-1:0]  lru_rank;
      logic [RANK_W-1:0]  hit_rank;
   } cmd_type;

   // Handed from one cell to the next.
   typedef struct packed {
      logic               hit_seen;
      logic               free_seen;
      logic [VALUE_W-1:0] value;
      logic [RANK_W-1:0]  rank;
   } link_type;

endpackage

### hw/rtl/lkv_cell.sv
// One cache entry: key, value, valid mark and recency rank.
`timescale 1ns / 1ps

module lkv_cell
   import lkv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  link_type link_in,
   output link_type link_out,
   output logic     valid_out
);

   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   key_in;
   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic               valid_ff;
   logic               valid_in;
   logic [RANK_W-1:0]  rank_ff;
   logic [RANK_W-1:0]  rank_in;
   logic               match;
   logic               free_first;
   logic               target;

   assign match      = valid_ff && (key_ff == cmd.key) && !link_in.hit_seen;
   assign free_first = !valid_ff && !link_in.free_seen;
   assign target     = cmd.evict ? (valid_ff && (rank_ff == cmd.lru_rank)) : free_first;

   assign link_out.hit_seen  = link_in.hit_seen | match;
   assign link_out.free_seen = link_in.free_seen | !valid_ff;
   assign link_out.value     = link_in.value | (match ? value_ff : '0);
   assign link_out.rank      = link_in.rank | (match ? rank_ff : '0);
   assign valid_out          = valid_ff;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (cmd.fire) begin
         if (cmd.hit) begin
            if (match) begin
               rank_in = '0;
               if (cmd.op == OP_WRITE) begin
                  value_in = cmd.value;
               end
            end else if (valid_ff && (rank_ff < cmd.hit_rank)) begin
               rank_in = rank_ff + RANK_W'(1);
            end
         end else if (cmd.op == OP_WRITE) begin
            if (target) begin
               key_in   = cmd.key;
               value_in = cmd.value;
               valid_in = 1'b1;
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + RANK_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

endmodule

### hw/rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
// A request is held in the request stage until the response register can take it, then
// its response is registered and offered on the response stream.
// Throughput: one request per cycle while responses are taken.
// Reset clears every valid mark and rank, the occupancy count and both handshake stages;
// capacity returns to 16. Key and value storage is not reset.
`timescale 1ns / 1ps

module lru_key_value_cache
   import lkv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key [31:0], value [63:32]
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_value [31:0]
   output logic        rsp_tuser,   // found
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata    // capacity_in_use
);

   logic [CAP_W-1:0]   cap_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] cap_eff;

   logic               pend_valid_ff;
   logic               pend_op_ff;
   logic [KEY_W-1:0]   pend_key_ff;
   logic [VALUE_W-1:0] pend_value_ff;

   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   logic               fire;
   logic               hit;
   cmd_type            cmd;
   link_type           links [0:MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_vec;

   assign fire       = pend_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_valid_ff || fire;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_found_ff;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = COUNT_W'(1);
      end else if (32'(cap_ff) > 32'(MAX_ENTRIES)) begin
         cap_eff = COUNT_W'(MAX_ENTRIES);
      end else begin
         cap_eff = COUNT_W'(cap_ff);
      end
   end

   assign links[0] = '0;
   assign hit      = links[MAX_ENTRIES].hit_seen;

   assign cmd.fire     = fire;
   assign cmd.op       = pend_op_ff;
   assign cmd.key      = pend_key_ff;
   assign cmd.value    = pend_value_ff;
   assign cmd.hit      = hit;
   assign cmd.evict    = (count_ff >= cap_eff);
   assign cmd.lru_rank = RANK_W'(count_ff - COUNT_W'(1));
   assign cmd.hit_rank = links[MAX_ENTRIES].rank;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      lkv_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .link_in  (links[i]),
         .link_out (links[i+1]),
         .valid_out(valid_vec[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (fire && !hit && (pend_op_ff == OP_WRITE) && !cmd.evict) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         pend_op_ff    <= req_tuser;
         pend_key_ff   <= req_tdata[31:0];
         pend_value_ff <= req_tdata[63:32];
      end
      if (fire) begin
         rsp_found_ff <= hit;
         rsp_value_ff <= (hit && (pend_op_ff == OP_LOOKUP)) ? links[MAX_ENTRIES].value : '1;
      end
      if (reset) begin
         cap_ff        <= CAP_W'(CAP_RESET);
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         count_ff <= count_in;
         if (req_tvalid && req_tready) begin
            pend_valid_ff <= 1'b1;
         end else if (fire) begin
            pend_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("occupancy count differs from valid cells");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_ENTRIES))
      else $error("occupancy count above entry count");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("handshake stages not idle after reset");

   a_write_rsp_ones: assert property (@(posedge clock) disable iff (reset)
      (fire && (pend_op_ff == OP_WRITE)) |=> (rsp_tdata == '1))
      else $error("write response value not all ones");

endmodule

### tb/lru_key_value_cache_test.sv
// Self-checking testbench for the LRU key-value cache: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module lru_key_value_cache_test
   import lkv_pkg::*;
;

   typedef struct packed {
      logic               op;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } cache_request_type;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] read_value;
   } cache_response_type;

   localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
   localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;
   localparam logic [KEY_W-1:0] ALL_ONES = 32'hffff_ffff;
   localparam int POOL_SIZE = 24;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [4:0]  csr_wdata = '0;

   lru_key_value_cache DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   cache_request_type  pending_reqs[$];
   cache_response_type expected_rsps[$];

   // shadow copy of the cache state
   logic [KEY_W-1:0]   shadow_key   [MAX_ENTRIES];
   logic [VALUE_W-1:0] shadow_value [MAX_ENTRIES];
   logic               shadow_valid [MAX_ENTRIES];
   logic [RANK_W-1:0]  shadow_rank  [MAX_ENTRIES];
   logic [CAP_W-1:0]   shadow_capacity = CAP_RESET[CAP_W-1:0];

   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   int unsigned send_gap_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned error_count = 0;
   int unsigned transfer_count = 0;
   int unsigned checked_count = 0;
   int unsigned hit_count = 0;
   int unsigned evict_count = 0;
   int unsigned capacity_settings = 0;

   function automatic void promote_entry(input int idx);
      logic [RANK_W-1:0] old_rank;
      old_rank = shadow_rank[idx];
      for (int j = 0; j < MAX_ENTRIES; j++)
         if (j != idx && shadow_valid[j] && shadow_rank[j] < old_rank)
            shadow_rank[j] = shadow_rank[j] + 1'b1;
      shadow_rank[idx] = '0;
   endfunction

   function automatic cache_response_type access_cache(input cache_request_type item);
      cache_response_type resp;
      int unsigned       eff_cap;
      int unsigned       occupancy;
      int                hit_idx;
      int                free_idx;
      int                lru_idx;
      int                slot;
      logic [RANK_W-1:0] lru_rank;
      eff_cap = shadow_capacity;
      if (eff_cap == 0) eff_cap = 1;
      if (eff_cap > MAX_ENTRIES) eff_cap = MAX_ENTRIES;
      occupancy = 0;
      hit_idx = -1;
      free_idx = -1;
      lru_idx = -1;
      lru_rank = '0;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         if (shadow_valid[j]) begin
            occupancy++;
            if (hit_idx < 0 && shadow_key[j] == item.key) hit_idx = j;
            if (lru_idx < 0 || shadow_rank[j] > lru_rank) begin
               lru_idx = j;
               lru_rank = shadow_rank[j];
            end
         end else if (free_idx < 0) begin
            free_idx = j;
         end
      end
      resp.found = (hit_idx >= 0);
      resp.read_value = ALL_ONES;
      if (resp.found) hit_count++;
      if (hit_idx >= 0) begin
         if (item.op == OP_LOOKUP) resp.read_value = shadow_value[hit_idx];
         else shadow_value[hit_idx] = item.value;
         promote_entry(hit_idx);
      end else if (item.op == OP_WRITE) begin
         if (occupancy >= eff_cap || free_idx < 0) begin
            slot = lru_idx;
            shadow_valid[slot] = 1'b0;
            evict_count++;
         end else begin
            slot = free_idx;
         end
         for (int j = 0; j < MAX_ENTRIES; j++)
            if (shadow_valid[j]) shadow_rank[j] = shadow_rank[j] + 1'b1;
         shadow_key[slot] = item.key;
         shadow_value[slot] = item.value;
         shadow_valid[slot] = 1'b1;
         shadow_rank[slot] = '0;
      end
      return resp;
   endfunction

   // driver: holds an item until its transfer, predicts at the transfer
   always @(posedge clock) begin : drive_requests
      cache_request_type head;
      logic              send;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            head = pending_reqs.pop_front();
            expected_rsps.push_back(access_cache(head));
            transfer_count++;
         end
         send = 1'b0;
         if (req_tvalid && !req_tready) send = 1'b1;
         else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
            send = 1'b1;
         if (send) begin
            req_tvalid <= 1'b1;
            req_tdata <= {pending_reqs[0].value, pending_reqs[0].key};
            req_tuser <= pending_reqs[0].op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: checks each response transfer against the oldest prediction
   always @(posedge clock) begin : check_responses
      cache_response_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $error("response transfer with none expected: found=%0b read_value=%h",
                      rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               checked_count++;
               if (rsp_tuser !== want.found) begin
                  $error("found: expected %0b, actual %0b", want.found, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata !== want.read_value) begin
                  $error("read_value: expected %h, actual %h", want.read_value, rsp_tdata);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic push_item(input logic op, input logic [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] value);
      cache_request_type item;
      item.op = op;
      item.key = key;
      item.value = value;
      pending_reqs.push_back(item);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_tvalid)
         @(negedge clock);
   endtask

   task automatic start_phase(input logic [CAP_W-1:0] cap, input int unsigned gap_pct,
                              input int unsigned stall_pct);
      wait_idle();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_capacity = cap;
      capacity_settings++;
      @(negedge clock);
      send_gap_pct = gap_pct;
      recv_stall_pct = stall_pct;
   endtask

   task automatic push_random(input int n, input int pool_n);
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic               op;
      for (int i = 0; i < n; i++) begin
         op = ($urandom_range(0, 99) < 45) ? OP_LOOKUP : OP_WRITE;
         if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, pool_n - 1)];
         else key = $urandom;
         case ($urandom_range(0, 9))
            0: value = KEY_MIN;
            1: value = KEY_MAX;
            2: value = ALL_ONES;
            default: value = $urandom;
         endcase
         push_item(op, key, value);
      end
   endtask

   initial begin
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = '0;
      key_pool[3] = ALL_ONES;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         shadow_key[i] = '0;
         shadow_value[i] = '0;
         shadow_valid[i] = 1'b0;
         shadow_rank[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, hits, overwrite of a present key
      start_phase(5'd16, 0, 0);
      push_item(OP_LOOKUP, KEY_MIN, '0);
      push_item(OP_WRITE, KEY_MIN, KEY_MAX);
      push_item(OP_WRITE, KEY_MAX, KEY_MIN);
      push_item(OP_WRITE, '0, '0);
      push_item(OP_WRITE, ALL_ONES, ALL_ONES);
      push_item(OP_LOOKUP, KEY_MIN, ALL_ONES);
      push_item(OP_LOOKUP, KEY_MAX, '0);
      push_item(OP_LOOKUP, '0, '0);
      push_item(OP_LOOKUP, ALL_ONES, '0);
      push_item(OP_LOOKUP, 32'd1, '0);
      push_item(OP_WRITE, '0, 32'h1234_5678);
      push_item(OP_LOOKUP, '0, '0);

      // capacity below occupancy: each new key evicts exactly one
      start_phase(5'd2, 0, 0);
      push_item(OP_WRITE, 32'd5, 32'd55);
      push_item(OP_LOOKUP, KEY_MIN, '0);
      push_item(OP_WRITE, KEY_MAX, 32'd7);
      push_item(OP_LOOKUP, ALL_ONES, '0);
      push_item(OP_WRITE, 32'd6, 32'd66);

      // capacity zero behaves as one
      start_phase(5'd0, 0, 0);
      push_item(OP_WRITE, 32'd7, 32'd77);
      push_item(OP_LOOKUP, 32'd7, '0);
      push_item(OP_WRITE, 32'd8, 32'd88);
      push_item(OP_LOOKUP, 32'd7, '0);
      push_item(OP_LOOKUP, 32'd8, '0);

      start_phase(5'd16, 0, 0);
      push_random(100, 20);
      start_phase(5'd31, 74, 0);
      push_random(100, 20);
      start_phase(5'd1, 0, 74);
      push_random(100, 3);
      start_phase(5'd7, 15, 15);
      push_random(100, 10);
      start_phase(5'd17, 0, 0);
      push_random(50, POOL_SIZE);
      start_phase(5'd3, 15, 15);
      push_random(50, 6);

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Ran %0d request transfers over %0d capacity settings, %0d responses checked.",
               transfer_count, capacity_settings, checked_count);
      $display("Saw %0d hits and %0d evictions under varied sender gaps and receiver stalls.",
               hit_count, evict_count);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
